// ===== rtl/core/bgc_pkg.sv =====
package bgc_pkg;

  localparam int DebounceW = 8;
  localparam int TicksW = 16;
  localparam int EnableW = 4;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  typedef logic [1:0] gesture_t;

  localparam gesture_t G_SINGLE      = 2'd0;
  localparam gesture_t G_DOUBLE      = 2'd1;
  localparam gesture_t G_LONG        = 2'd2;
  localparam gesture_t G_CLICK_PRESS = 2'd3;

  typedef enum logic [2:0] {
    REG_DEBOUNCE       = 3'd0,
    REG_LONG_PRESS     = 3'd1,
    REG_CLICK_GAP      = 3'd2,
    REG_DOUBLE_RELEASE = 3'd3,
    REG_ENABLE         = 3'd4
  } reg_index_t;

  localparam logic [DebounceW-1:0] DEBOUNCE_RESET       = 8'd10;
  localparam logic [TicksW-1:0]    LONG_PRESS_RESET     = 16'd3000;
  localparam logic [TicksW-1:0]    CLICK_GAP_RESET      = 16'd500;
  localparam logic [TicksW-1:0]    DOUBLE_RELEASE_RESET = 16'd600;
  localparam logic [EnableW-1:0]   ENABLE_RESET         = 4'hF;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ticks;
    logic [TicksW-1:0]    long_press_ticks;
    logic [TicksW-1:0]    click_gap_ticks;
    logic [TicksW-1:0]    double_release_ticks;
    logic [EnableW-1:0]   gesture_enable;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    gesture_t gesture;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/bgc_tick_if.sv =====
interface bgc_tick_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

// ===== rtl/core/bgc_gesture_if.sv =====
interface bgc_gesture_if;
  logic              valid;
  logic              ready;
  bgc_pkg::gesture_t gesture;

  modport source (output valid, output gesture, input ready);
  modport sink (input valid, input gesture, output ready);
endinterface

// ===== rtl/core/bgc_front.sv =====
module bgc_front #(
  parameter int TIMER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  bgc_tick_if.sink           tick,
  input  bgc_pkg::cfg_t      cfg,
  input  bgc_pkg::q_status_t q_status,
  output bgc_pkg::item_t     push_item
);

  localparam int CmpW = (TIMER_BITS > bgc_pkg::TicksW) ? TIMER_BITS : bgc_pkg::TicksW;

  typedef enum logic [4:0] {
    ST_IDLE         = 5'b00001,
    ST_FIRST_PRESS  = 5'b00010,
    ST_SINGLE_CLICK = 5'b00100,
    ST_SECOND_PRESS = 5'b01000,
    ST_DOUBLE_CLICK = 5'b10000
  } state_t;

  state_t                           state, state_next, state_mid;
  logic                             debounced_pressed, debounced_pressed_next;
  logic [bgc_pkg::DebounceW-1:0]    since_change, since_change_next, since_inc;
  logic [TIMER_BITS-1:0]            timeout_left, timeout_left_next;
  logic                             timeout_armed, timeout_armed_next;
  logic                             accept;
  logic                             pressed;
  logic                             fire;
  bgc_pkg::gesture_t                g;

  function automatic logic [TIMER_BITS-1:0] timeout_load(input logic [bgc_pkg::TicksW-1:0] ticks);
    logic [CmpW-1:0] v;
    v = CmpW'(ticks);
    if (v == '0) begin
      v = CmpW'(1);
    end
    if (v > CmpW'({TIMER_BITS{1'b1}})) begin
      v = CmpW'({TIMER_BITS{1'b1}});
    end
    return TIMER_BITS'(v);
  endfunction

  assign tick.ready = !q_status.full;
  assign accept     = tick.valid && tick.ready;
  assign pressed    = !tick.pin_level;

  always_comb begin
    since_inc = (since_change != {bgc_pkg::DebounceW{1'b1}}) ?
                since_change + 1'b1 : since_change;
    state_mid              = state;
    timeout_armed_next     = timeout_armed;
    timeout_left_next      = timeout_left;
    debounced_pressed_next = debounced_pressed;
    since_change_next      = since_inc;
    fire                   = 1'b0;
    g                      = bgc_pkg::G_SINGLE;

    // timeout countdown and gesture report
    if (timeout_armed) begin
      timeout_left_next = (timeout_left != '0) ? timeout_left - 1'b1 : timeout_left;
      if (timeout_left_next == '0) begin
        timeout_armed_next = 1'b0;
        unique case (state)
          ST_FIRST_PRESS: begin
            fire = 1'b1;
            g    = bgc_pkg::G_LONG;
          end
          ST_SINGLE_CLICK: begin
            fire = 1'b1;
            g    = bgc_pkg::G_SINGLE;
          end
          ST_SECOND_PRESS: begin
            fire = 1'b1;
            g    = bgc_pkg::G_CLICK_PRESS;
          end
          ST_DOUBLE_CLICK: begin
            fire = 1'b1;
            g    = bgc_pkg::G_DOUBLE;
          end
          default: fire = 1'b0;
        endcase
        state_mid = ST_IDLE;
      end
    end

    state_next = state_mid;

    // debounced level change
    if (pressed != debounced_pressed && since_inc >= cfg.debounce_ticks) begin
      debounced_pressed_next = pressed;
      since_change_next      = '0;
      unique case (state_mid)
        ST_IDLE: begin
          if (pressed) begin
            state_next         = ST_FIRST_PRESS;
            timeout_left_next  = timeout_load(cfg.long_press_ticks);
            timeout_armed_next = 1'b1;
          end
        end
        ST_FIRST_PRESS: begin
          if (!pressed) begin
            state_next         = ST_SINGLE_CLICK;
            timeout_left_next  = timeout_load(cfg.click_gap_ticks);
            timeout_armed_next = 1'b1;
          end
        end
        ST_SINGLE_CLICK: begin
          if (pressed) begin
            state_next         = ST_SECOND_PRESS;
            timeout_left_next  = timeout_load(cfg.long_press_ticks);
            timeout_armed_next = 1'b1;
          end
        end
        ST_SECOND_PRESS: begin
          if (!pressed) begin
            state_next         = ST_DOUBLE_CLICK;
            timeout_left_next  = timeout_load(cfg.double_release_ticks);
            timeout_armed_next = 1'b1;
          end
        end
        default: state_next = state_mid;
      endcase
    end
  end

  assign push_item.valid   = accept && fire && cfg.gesture_enable[g];
  assign push_item.gesture = g;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      debounced_pressed <= 1'b0;
      since_change      <= '0;
      timeout_left      <= '0;
      timeout_armed     <= 1'b0;
    end else if (accept) begin
      state             <= state_next;
      debounced_pressed <= debounced_pressed_next;
      since_change      <= since_change_next;
      timeout_left      <= timeout_left_next;
      timeout_armed     <= timeout_armed_next;
    end
  end

endmodule

// ===== rtl/core/bgc_queue.sv =====
module bgc_queue (
  input  logic               clk,
  input  logic               rst,
  input  bgc_pkg::item_t     push_item,
  input  logic               pop,
  output bgc_pkg::gesture_t  head,
  output bgc_pkg::q_status_t status
);

  bgc_pkg::gesture_t               mem [bgc_pkg::QueueDepth];
  logic [bgc_pkg::QueuePtrW-1:0]   wr_ptr, rd_ptr;
  logic [bgc_pkg::QueueCntW-1:0]   count;
  logic                            do_push, do_pop;

  assign status.full  = (count == bgc_pkg::QueueCntW'(bgc_pkg::QueueDepth));
  assign status.empty = (count == '0);
  assign do_push      = push_item.valid && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item.gesture;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == bgc_pkg::QueuePtrW'(bgc_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == bgc_pkg::QueuePtrW'(bgc_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/bgc_back.sv =====
module bgc_back (
  input  logic               clk,
  input  logic               rst,
  input  bgc_pkg::gesture_t  head,
  input  bgc_pkg::q_status_t q_status,
  output logic               pop,
  bgc_gesture_if.source      result
);

  logic              out_valid;
  bgc_pkg::gesture_t out_gesture;

  assign pop            = !q_status.empty && (!out_valid || result.ready);
  assign result.valid   = out_valid;
  assign result.gesture = out_gesture;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_gesture <= head;
    end
  end

endmodule

// ===== rtl/core/button_gesture_classifier_core.sv =====
// Button gesture classifier. Each tick transfer carries one millisecond sample of the raw
// active-low button pin; the block debounces it, tracks press and release timing and emits
// single click, double click, long press or click-and-press results when the matching
// timeout runs out and the gesture is enabled. One tick is taken every clock cycle: the
// classifier updates its state registers on each accepted tick, results pass through a
// two-entry queue into an output register, and the tick side stalls only when that queue
// is full behind a stalled result. Registers must be written over the APB port only while
// no ticks are in flight; the user is bound by this, the block itself does not enforce it.
module button_gesture_classifier_core #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  bgc_tick_if.sink    tick,
  bgc_gesture_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bgc_pkg::cfg_t      cfg;
  bgc_pkg::item_t     push_item;
  bgc_pkg::q_status_t q_status;
  bgc_pkg::gesture_t  head;
  logic               pop;
  logic               reg_write;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks       <= bgc_pkg::DEBOUNCE_RESET;
      cfg.long_press_ticks     <= bgc_pkg::LONG_PRESS_RESET;
      cfg.click_gap_ticks      <= bgc_pkg::CLICK_GAP_RESET;
      cfg.double_release_ticks <= bgc_pkg::DOUBLE_RELEASE_RESET;
      cfg.gesture_enable       <= bgc_pkg::ENABLE_RESET;
    end else if (reg_write) begin
      unique case (paddr[4:2])
        bgc_pkg::REG_DEBOUNCE:       cfg.debounce_ticks       <= pwdata[bgc_pkg::DebounceW-1:0];
        bgc_pkg::REG_LONG_PRESS:     cfg.long_press_ticks     <= pwdata[bgc_pkg::TicksW-1:0];
        bgc_pkg::REG_CLICK_GAP:      cfg.click_gap_ticks      <= pwdata[bgc_pkg::TicksW-1:0];
        bgc_pkg::REG_DOUBLE_RELEASE: cfg.double_release_ticks <= pwdata[bgc_pkg::TicksW-1:0];
        bgc_pkg::REG_ENABLE:         cfg.gesture_enable       <= pwdata[bgc_pkg::EnableW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      bgc_pkg::REG_DEBOUNCE:       prdata = 32'(cfg.debounce_ticks);
      bgc_pkg::REG_LONG_PRESS:     prdata = 32'(cfg.long_press_ticks);
      bgc_pkg::REG_CLICK_GAP:      prdata = 32'(cfg.click_gap_ticks);
      bgc_pkg::REG_DOUBLE_RELEASE: prdata = 32'(cfg.double_release_ticks);
      bgc_pkg::REG_ENABLE:         prdata = 32'(cfg.gesture_enable);
      default:                     prdata = '0;
    endcase
  end

  bgc_front #(
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .cfg      (cfg),
    .q_status (q_status),
    .push_item(push_item)
  );

  bgc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  bgc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ===== rtl/core/bgc_checker.sv =====
module bgc_checker (
  input logic clk,
  input logic rst,
  input logic tick_valid,
  input logic tick_ready,
  input logic result_valid,
  input logic result_ready
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // tick side only backs up behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    !tick_ready |-> $past(result_valid && !result_ready))
    else $error("tick stalled without a stalled result");

  // a fresh result comes from an earlier tick transfer pushed through the queue
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(tick_valid && tick_ready, 2))
    else $error("result without a causing tick");

endmodule

bind button_gesture_classifier_core bgc_checker u_bgc_checker (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick.valid),
  .tick_ready  (tick.ready),
  .result_valid(result.valid),
  .result_ready(result.ready)
);
